[rtl/text_overlay_glyph_rasterizer_unit_assert.svh]
// Assertion macros shared by the checker of the text overlay.
`ifndef TEXT_OVERLAY_GLYPH_RASTERIZER_UNIT_ASSERT_SVH
`define TEXT_OVERLAY_GLYPH_RASTERIZER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOG_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("text overlay: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define TOG_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("text overlay: next-cycle check failed");

`endif

[rtl/tog_pkg.sv]
`default_nettype none

package tog_pkg;

    // Internal widths, sized for the largest legal text length, scale and screen.
    localparam int SCALE_W     = 5;
    localparam int SIDX_W      = 4;
    localparam int SCALE_LIMIT = 16;
    localparam int LEN_W       = 9;
    localparam int CELL_W      = 7;
    localparam int LCELL_W     = 15;
    localparam int POS_W       = 17;
    localparam int DX_W        = 15;
    localparam int IDX_W       = 13;
    localparam int BASE_W      = IDX_W + CELL_W;
    localparam int RECIP_SHIFT = DX_W + CELL_W;
    localparam int RECIP_W     = RECIP_SHIFT - 2;
    localparam int PROD_W      = DX_W + RECIP_W;
    localparam int PIPE_DEPTH  = 6;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COUNT = 41;
    localparam int SLOT_W      = 6;

    localparam logic [SLOT_W-1:0] SLOT_LETTER  = 6'd10;
    localparam logic [SLOT_W-1:0] SLOT_COLON   = 6'd36;
    localparam logic [SLOT_W-1:0] SLOT_PERCENT = 6'd37;
    localparam logic [SLOT_W-1:0] SLOT_MINUS   = 6'd38;
    localparam logic [SLOT_W-1:0] SLOT_DOT     = 6'd39;
    localparam logic [SLOT_W-1:0] SLOT_BLANK   = 6'd40;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
    localparam logic [7:0] CH_COLON    = 8'h3a;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_DOT      = 8'h2e;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [1:0] MODE_CENTRED = 2'd1;
    localparam logic [1:0] MODE_CLIP    = 2'd2;

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_GLYPH_SCALE = 3'd2,
        REG_TEXT_COLOR  = 3'd3,
        REG_TEXT_LENGTH = 3'd4,
        REG_CLIP_WIDTH  = 3'd5,
        REG_LAYOUT_MODE = 3'd6
    } cfg_reg_t;

    typedef logic [RECIP_W-1:0] recip_t;

    // Reciprocals of the cell width 6*scale, rounded up, for scales 1 to 16.
    localparam recip_t CELL_RECIP [SCALE_LIMIT] = '{
        RECIP_W'(((2**RECIP_SHIFT) +  5) /  6), RECIP_W'(((2**RECIP_SHIFT) + 11) / 12),
        RECIP_W'(((2**RECIP_SHIFT) + 17) / 18), RECIP_W'(((2**RECIP_SHIFT) + 23) / 24),
        RECIP_W'(((2**RECIP_SHIFT) + 29) / 30), RECIP_W'(((2**RECIP_SHIFT) + 35) / 36),
        RECIP_W'(((2**RECIP_SHIFT) + 41) / 42), RECIP_W'(((2**RECIP_SHIFT) + 47) / 48),
        RECIP_W'(((2**RECIP_SHIFT) + 53) / 54), RECIP_W'(((2**RECIP_SHIFT) + 59) / 60),
        RECIP_W'(((2**RECIP_SHIFT) + 65) / 66), RECIP_W'(((2**RECIP_SHIFT) + 71) / 72),
        RECIP_W'(((2**RECIP_SHIFT) + 77) / 78), RECIP_W'(((2**RECIP_SHIFT) + 83) / 84),
        RECIP_W'(((2**RECIP_SHIFT) + 89) / 90), RECIP_W'(((2**RECIP_SHIFT) + 95) / 96)
    };

    // Column font: one byte per dot column, bit 0 is the top row.
    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
        '{8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e}, '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00},
        '{8'h62, 8'h51, 8'h49, 8'h49, 8'h46}, '{8'h22, 8'h41, 8'h49, 8'h49, 8'h36},
        '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10}, '{8'h2f, 8'h49, 8'h49, 8'h49, 8'h31},
        '{8'h3e, 8'h49, 8'h49, 8'h49, 8'h32}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h26, 8'h49, 8'h49, 8'h49, 8'h3e},
        '{8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e}, '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c},
        '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a}, '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f},
        '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3f, 8'h01},
        '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f}, '{8'h7f, 8'h02, 8'h0c, 8'h10, 8'h7f},
        '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e}, '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01},
        '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}, '{8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f},
        '{8'h7f, 8'h20, 8'h18, 8'h20, 8'h7f}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic signed [10:0] origin_x;
        logic [9:0]         origin_y;
        logic [3:0]         glyph_scale;
        logic [15:0]        text_color;
        logic [5:0]         text_length;
        logic [9:0]         clip_width;
        logic [1:0]         layout_mode;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  char_index;
        logic [7:0]  char_code;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [15:0] background;
    } req_t;

    // Fields that ride unchanged down the pipeline.
    typedef struct packed {
        logic        kind;
        logic [4:0]  char_index;
        logic [7:0]  char_code;
        logic [15:0] background;
    } ctx_t;

    typedef struct packed {
        ctx_t               ctx;
        logic [9:0]         pixel_x;
        logic [9:0]         pixel_y;
        logic               offscreen;
        logic [SCALE_W-1:0] scale;
        logic [CELL_W-1:0]  pitch;
        logic [LEN_W-1:0]   len;
        logic [LCELL_W-1:0] len_cell;
    } lay_t;

    typedef struct packed {
        ctx_t               ctx;
        logic               miss;
        logic [DX_W-1:0]    dx;
        logic [9:0]         dy;
        logic [SCALE_W-1:0] scale;
        logic [CELL_W-1:0]  pitch;
        logic [LEN_W-1:0]   len;
    } geo_t;

    typedef struct packed {
        ctx_t               ctx;
        logic               miss;
        logic [DX_W-1:0]    dx;
        logic [IDX_W-1:0]   idx;
        logic [2:0]         row;
        logic [SCALE_W-1:0] scale;
        logic [CELL_W-1:0]  pitch;
        logic [LEN_W-1:0]   len;
    } div_t;

    typedef struct packed {
        ctx_t               ctx;
        logic               miss;
        logic [IDX_W-1:0]   idx;
        logic [CELL_W-1:0]  rem;
        logic [2:0]         row;
        logic [SCALE_W-1:0] scale;
    } pos_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] background;
        logic        miss;
        logic [2:0]  col;
        logic [2:0]  row;
    } look_t;

    // Font slot of a character code; lower case folds to upper case.
    function automatic logic [SLOT_W-1:0] glyph_slot(input logic [7:0] code);
        logic [7:0]        c;
        logic [SLOT_W-1:0] slot;
        c = code;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            c = c - CASE_OFFSET;
        end
        slot = SLOT_BLANK;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            slot = SLOT_W'(c - CH_ZERO);
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            slot = SLOT_W'(c - CH_UPPER_A) + SLOT_LETTER;
        end
        else if (c == CH_COLON)
        begin
            slot = SLOT_COLON;
        end
        else if (c == CH_PERCENT)
        begin
            slot = SLOT_PERCENT;
        end
        else if (c == CH_MINUS)
        begin
            slot = SLOT_MINUS;
        end
        else if (c == CH_DOT)
        begin
            slot = SLOT_DOT;
        end
        return slot;
    endfunction

endpackage

`default_nettype wire

[rtl/tog_if.sv]
`default_nettype none

interface tog_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [4:0]  char_index;
    logic [7:0]  char_code;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] background;

    modport source (output valid, kind, char_index, char_code, pixel_x, pixel_y, background,
                    input ready);
    modport sink (input valid, kind, char_index, char_code, pixel_x, pixel_y, background,
                  output ready);
endinterface

interface tog_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic        covered;

    modport source (output valid, pixel_color, covered, input ready);
    modport sink (input valid, pixel_color, covered, output ready);
endinterface

`default_nettype wire

[rtl/tog_layout.sv]
`default_nettype none

module tog_layout #(
    parameter int LINE_CHARS   = 32,
    parameter int SCREEN_WIDTH = 240,
    parameter int MAX_SCALE    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tog_pkg::cfg_t cfg,
    input  logic          up_valid,
    output logic          up_ready,
    input  tog_pkg::req_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output tog_pkg::geo_t dn_data
);
    import tog_pkg::*;

    logic a_valid_reg;
    lay_t a_reg;
    lay_t a_next;
    logic b_valid_reg;
    geo_t b_reg;
    geo_t b_next;
    logic a_en;
    logic b_en;

    assign b_en     = !b_valid_reg || dn_ready;
    assign a_en     = !a_valid_reg || b_en;
    assign up_ready = a_en;
    assign dn_valid = b_valid_reg;
    assign dn_data  = b_reg;

    // Clamped scale and length, cell width and the unclipped line span.
    always_comb
    begin
        logic [SCALE_W-1:0] scale_raw;
        logic [SCALE_W-1:0] scale_c;
        logic [LEN_W-1:0]   len_raw;
        logic [LEN_W-1:0]   len_c;
        logic [CELL_W-1:0]  pitch;
        scale_raw = SCALE_W'(cfg.glyph_scale);
        if (scale_raw == '0)
        begin
            scale_c = SCALE_W'(1);
        end
        else if (scale_raw > SCALE_W'(MAX_SCALE))
        begin
            scale_c = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            scale_c = scale_raw;
        end
        len_raw = LEN_W'(cfg.text_length);
        len_c   = (len_raw > LEN_W'(LINE_CHARS)) ? LEN_W'(LINE_CHARS) : len_raw;
        pitch   = (CELL_W'(scale_c) << 2) + (CELL_W'(scale_c) << 1);

        a_next.ctx.kind       = up_data.kind;
        a_next.ctx.char_index = up_data.char_index;
        a_next.ctx.char_code  = up_data.char_code;
        a_next.ctx.background = up_data.background;
        a_next.pixel_x        = up_data.pixel_x;
        a_next.pixel_y        = up_data.pixel_y;
        a_next.offscreen      = up_data.pixel_x >= 10'(SCREEN_WIDTH);
        a_next.scale          = scale_c;
        a_next.pitch          = pitch;
        a_next.len            = len_c;
        a_next.len_cell       = LCELL_W'(len_c) * LCELL_W'(pitch);
    end

    // Line origin and offsets of the pixel from it.
    always_comb
    begin
        logic [LCELL_W-1:0]      width;
        logic signed [POS_W-1:0] span;
        logic signed [POS_W-1:0] round_c;
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] dx;
        logic signed [10:0]      dy;
        width   = (a_reg.len == '0) ? '0 : a_reg.len_cell - LCELL_W'(a_reg.scale);
        span    = $signed(POS_W'(SCREEN_WIDTH)) - $signed({2'b00, width});
        // The shift rounds down; negative spans are nudged up to truncate.
        round_c = $signed({{(POS_W-1){1'b0}}, span[POS_W-1]});
        if (cfg.layout_mode == MODE_CENTRED)
        begin
            x0 = (span + round_c) >>> 1;
        end
        else
        begin
            x0 = $signed({{(POS_W-11){cfg.origin_x[10]}}, cfg.origin_x});
        end
        dx = $signed({{(POS_W-10){1'b0}}, a_reg.pixel_x}) - x0;
        dy = $signed({1'b0, a_reg.pixel_y}) - $signed({1'b0, cfg.origin_y});

        b_next.ctx   = a_reg.ctx;
        b_next.miss  = a_reg.offscreen || dx[POS_W-1] || dy[10];
        b_next.dx    = dx[DX_W-1:0];
        b_next.dy    = dy[9:0];
        b_next.scale = a_reg.scale;
        b_next.pitch = a_reg.pitch;
        b_next.len   = a_reg.len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && up_valid)
        begin
            a_reg <= a_next;
        end
        if (b_en && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tog_divide.sv]
`default_nettype none

module tog_divide (
    input  logic          clk,
    input  logic          rst_n,
    input  tog_pkg::cfg_t cfg,
    input  logic          up_valid,
    output logic          up_ready,
    input  tog_pkg::geo_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output tog_pkg::pos_t dn_data
);
    import tog_pkg::*;

    logic c_valid_reg;
    div_t c_reg;
    div_t c_next;
    logic d_valid_reg;
    pos_t d_reg;
    pos_t d_next;
    logic c_en;
    logic d_en;

    assign d_en     = !d_valid_reg || dn_ready;
    assign c_en     = !c_valid_reg || d_en;
    assign up_ready = c_en;
    assign dn_valid = d_valid_reg;
    assign dn_data  = d_reg;

    // Cell index by reciprocal multiply, exact over the whole offset range,
    // and the dot row by comparing against multiples of the scale.
    always_comb
    begin
        logic [SIDX_W-1:0] sidx;
        logic [PROD_W-1:0] prod;
        logic [9:0]        row_thr;
        logic [2:0]        row_cnt;
        sidx    = SIDX_W'(up_data.scale - SCALE_W'(1));
        prod    = PROD_W'(up_data.dx) * PROD_W'(CELL_RECIP[sidx]);
        row_thr = '0;
        row_cnt = '0;
        for (int k = 0; k < GLYPH_ROWS; k++)
        begin
            row_thr = row_thr + 10'(up_data.scale);
            if (up_data.dy >= row_thr)
            begin
                row_cnt = row_cnt + 3'd1;
            end
        end
        c_next.ctx   = up_data.ctx;
        c_next.miss  = up_data.miss || (row_cnt == 3'(GLYPH_ROWS));
        c_next.dx    = up_data.dx;
        c_next.idx   = prod[RECIP_SHIFT +: IDX_W];
        c_next.row   = row_cnt;
        c_next.scale = up_data.scale;
        c_next.pitch = up_data.pitch;
        c_next.len   = up_data.len;
    end

    // Offset inside the cell, line length and the clip test.
    always_comb
    begin
        logic [BASE_W-1:0] base;
        logic [DX_W-1:0]   rem_full;
        logic [CELL_W-1:0] five_s;
        logic              fits;
        logic              beyond;
        base     = BASE_W'(c_reg.idx) * BASE_W'(c_reg.pitch);
        rem_full = c_reg.dx - base[DX_W-1:0];
        five_s   = (CELL_W'(c_reg.scale) << 2) + CELL_W'(c_reg.scale);
        // A cell is kept when its glyph ends within the clip width; the
        // first cell is always kept.
        fits     = (c_reg.idx == '0)
                   || (base + BASE_W'(five_s) <= BASE_W'(cfg.clip_width));
        beyond   = c_reg.idx >= IDX_W'(c_reg.len);

        d_next.ctx   = c_reg.ctx;
        d_next.miss  = c_reg.miss || beyond || ((cfg.layout_mode == MODE_CLIP) && !fits);
        d_next.idx   = c_reg.idx;
        d_next.rem   = rem_full[CELL_W-1:0];
        d_next.row   = c_reg.row;
        d_next.scale = c_reg.scale;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_en)
            begin
                c_valid_reg <= up_valid;
            end
            if (d_en)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en && up_valid)
        begin
            c_reg <= c_next;
        end
        if (d_en && c_valid_reg)
        begin
            d_reg <= d_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tog_glyph.sv]
`default_nettype none

module tog_glyph #(
    parameter int LINE_CHARS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tog_pkg::cfg_t cfg,
    input  logic          up_valid,
    output logic          up_ready,
    input  tog_pkg::pos_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output logic [15:0]   dn_color,
    output logic          dn_covered
);
    import tog_pkg::*;

    localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    logic [7:0]  store_mem [LINE_CHARS];
    logic [7:0]  code_reg;
    logic        e_valid_reg;
    look_t       e_reg;
    look_t       e_next;
    logic        out_valid_reg;
    logic [15:0] out_color_reg;
    logic [15:0] out_color_next;
    logic        out_covered_reg;
    logic        out_covered_next;
    logic        e_en;
    logic        f_en;
    logic        store_write;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    assign f_en       = !out_valid_reg || dn_ready;
    assign e_en       = !e_valid_reg || f_en;
    assign up_ready   = e_en;
    assign dn_valid   = out_valid_reg;
    assign dn_color   = out_color_reg;
    assign dn_covered = out_covered_reg;

    assign store_write = up_valid && (up_data.ctx.kind == KIND_WRITE)
                         && (LEN_W'(up_data.ctx.char_index) < LEN_W'(LINE_CHARS));
    assign waddr       = AW'(up_data.ctx.char_index);
    assign raddr       = AW'(up_data.idx);

    // Dot column inside the cell.
    always_comb
    begin
        logic [CELL_W-1:0] col_thr;
        logic [2:0]        col_cnt;
        col_thr = '0;
        col_cnt = '0;
        for (int k = 0; k < GLYPH_COLS; k++)
        begin
            col_thr = col_thr + CELL_W'(up_data.scale);
            if (up_data.rem >= col_thr)
            begin
                col_cnt = col_cnt + 3'd1;
            end
        end
        e_next.kind       = up_data.ctx.kind;
        e_next.background = up_data.ctx.background;
        e_next.miss       = up_data.miss || (col_cnt == 3'(GLYPH_COLS));
        e_next.col        = col_cnt;
        e_next.row        = up_data.row;
    end

    // Font lookup on the stored code and the final colour choice.
    always_comb
    begin
        logic [SLOT_W-1:0] slot;
        logic              hit;
        slot = glyph_slot(code_reg);
        hit  = (e_reg.kind == KIND_PIXEL) && !e_reg.miss
               && GLYPH_ROM[slot][e_reg.col][e_reg.row];
        out_covered_next = hit;
        if (e_reg.kind == KIND_WRITE)
        begin
            out_color_next = '0;
        end
        else if (hit)
        begin
            out_color_next = cfg.text_color;
        end
        else
        begin
            out_color_next = e_reg.background;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_en)
            begin
                e_valid_reg <= up_valid;
            end
            if (f_en)
            begin
                out_valid_reg <= e_valid_reg;
            end
        end
    end

    // Writes and reads share this stage, so they happen in request order.
    always_ff @(posedge clk)
    begin
        if (e_en && store_write)
        begin
            store_mem[waddr] <= up_data.ctx.char_code;
        end
        if (e_en && up_valid)
        begin
            code_reg <= store_mem[raddr];
            e_reg    <= e_next;
        end
        if (f_en && e_valid_reg)
        begin
            out_color_reg   <= out_color_next;
            out_covered_reg <= out_covered_next;
        end
    end

endmodule

`default_nettype wire

[rtl/text_overlay_glyph_rasterizer_unit.sv]
// Text overlay for one line of up to LINE_CHARS characters in a built-in 5x7 column
// font (digits, A-Z, colon, percent, minus and full stop; lower case is shown as
// upper case and every other code is a blank cell). Each request is either a
// character write into the text store or a pixel query; every request gives
// exactly one result, in request order. A pixel query returns the text colour
// where a glyph dot covers the pixel and the background otherwise; a character
// write returns colour zero, not covered. The block takes one request
// every clock cycle when the result side keeps up: the work runs
// through a six-register pipeline (layout
// and origin, cell index by reciprocal multiply, cell offset and clipping,
// text store read, font lookup into the output register), and each stage
// advances whenever the stage after it is empty or moving, so bubbles close
// up and a waiting result never holds back requests that still fit. The text
// store is not cleared at reset; a character must be written before it is
// shown. The configuration registers may be written only while no request is
// in flight, and the change applies to the next request.
`default_nettype none

module text_overlay_glyph_rasterizer_unit #(
    parameter int LINE_CHARS   = 32,
    parameter int SCREEN_WIDTH = 240,
    parameter int MAX_SCALE    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    tog_req_if.sink     request,
    tog_rsp_if.source   result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tog_pkg::*;

    // Configuration registers, reset to their documented defaults.
    logic signed [10:0] origin_x_reg;
    logic [9:0]         origin_y_reg;
    logic [3:0]         glyph_scale_reg;
    logic [15:0]        text_color_reg;
    logic [5:0]         text_length_reg;
    logic [9:0]         clip_width_reg;
    logic [1:0]         layout_mode_reg;
    cfg_t               cfg;

    req_t req;
    logic geo_valid;
    logic geo_ready;
    geo_t geo;
    logic pos_valid;
    logic pos_ready;
    pos_t pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            glyph_scale_reg <= 4'd1;
            text_color_reg  <= 16'hffff;
            text_length_reg <= '0;
            clip_width_reg  <= 10'd1023;
            layout_mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:    origin_x_reg    <= $signed(cfg_data[10:0]);
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data[9:0];
                REG_GLYPH_SCALE: glyph_scale_reg <= cfg_data[3:0];
                REG_TEXT_COLOR:  text_color_reg  <= cfg_data;
                REG_TEXT_LENGTH: text_length_reg <= cfg_data[5:0];
                REG_CLIP_WIDTH:  clip_width_reg  <= cfg_data[9:0];
                REG_LAYOUT_MODE: layout_mode_reg <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.origin_x    = origin_x_reg;
    assign cfg.origin_y    = origin_y_reg;
    assign cfg.glyph_scale = glyph_scale_reg;
    assign cfg.text_color  = text_color_reg;
    assign cfg.text_length = text_length_reg;
    assign cfg.clip_width  = clip_width_reg;
    assign cfg.layout_mode = layout_mode_reg;

    assign req.kind       = request.kind;
    assign req.char_index = request.char_index;
    assign req.char_code  = request.char_code;
    assign req.pixel_x    = request.pixel_x;
    assign req.pixel_y    = request.pixel_y;
    assign req.background = request.background;

    // Stages one and two: clamped settings, line origin and pixel offsets.
    tog_layout #(
        .LINE_CHARS   (LINE_CHARS),
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .MAX_SCALE    (MAX_SCALE)
    ) u_layout (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (request.valid),
        .up_ready (request.ready),
        .up_data  (req),
        .dn_valid (geo_valid),
        .dn_ready (geo_ready),
        .dn_data  (geo)
    );

    // Stages three and four: character cell, offset within it and clipping.
    tog_divide u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (geo_valid),
        .up_ready (geo_ready),
        .up_data  (geo),
        .dn_valid (pos_valid),
        .dn_ready (pos_ready),
        .dn_data  (pos)
    );

    // Stages five and six: text store, font lookup and the output register.
    tog_glyph #(
        .LINE_CHARS (LINE_CHARS)
    ) u_glyph (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (pos_valid),
        .up_ready   (pos_ready),
        .up_data    (pos),
        .dn_valid   (result.valid),
        .dn_ready   (result.ready),
        .dn_color   (result.pixel_color),
        .dn_covered (result.covered)
    );

endmodule

`default_nettype wire

[rtl/tog_checker.sv]
`default_nettype none

`include "text_overlay_glyph_rasterizer_unit_assert.svh"

module tog_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] pixel_color,
    input logic        covered,
    input logic        cfg_we,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data
);
    import tog_pkg::*;

    logic [15:0] color_reg;
    logic [3:0]  credit_reg;
    logic [3:0]  credit_next;

    assign credit_next = credit_reg + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg  <= 16'hffff;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (cfg_we && (cfg_index == REG_TEXT_COLOR))
            begin
                color_reg <= cfg_data;
            end
        end
    end

    `TOG_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `TOG_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(pixel_color) && $stable(covered))
    `TOG_ASSERT_IMPLY(a_cover_colour, clk, rst_n, rsp_valid && covered, pixel_color == color_reg)
    `TOG_ASSERT_IMPLY(a_no_spare_rsp, clk, rst_n, rsp_valid, credit_reg != 4'd0)
    `TOG_ASSERT_IMPLY(a_depth_bound, clk, rst_n, 1'b1, credit_reg <= 4'(PIPE_DEPTH))

endmodule

bind text_overlay_glyph_rasterizer_unit tog_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .rsp_valid   (result.valid),
    .rsp_ready   (result.ready),
    .pixel_color (result.pixel_color),
    .covered     (result.covered),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

// Testbench for the text overlay glyph rasterizer.
//
// Requests go in through the request channel and every request gives one
// result through the result channel, in request order. An overlay_model object
// keeps its own copy of the configuration registers, the text store and the
// font. It works out the colour that each accepted request should give and
// keeps it in a queue until the matching result arrives, where each field is
// compared.
//
// The configuration registers are written only when nothing is in flight.
// The run goes through a short directed part and then a series of layout
// settings, each followed by a burst of random requests. Most random pixel
// requests are aimed at the area that the text line covers. A pixel that
// would read a text store entry that has not yet been written is turned into
// a write to that entry, so the block never shows an undefined character.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tog_pkg::*;

    localparam int LINE_MAX  = 32;
    localparam int SCREEN_W  = 240;
    localparam int SCALE_MAX = 8;

    // Layout modes that the package leaves without a name.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int PHASES         = 14;
    localparam int PHASE_REQUESTS = 118;
    localparam int HOLD_LENGTH    = 120;
    localparam int SETTLE_CYCLES  = 10;

    // Own copy of the overlay: configuration, text store, font and the queue
    // of colours that accepted requests are still owed.
    class overlay_model;
        typedef struct packed {
            logic [15:0] pixel_color;
            logic        covered;
        } shade_t;

        cfg_t       settings;
        logic [7:0] line_text [LINE_MAX];
        logic [7:0] font [41][5];
        shade_t     colours_due [$];
        int         errors;
        int         results_seen;

        function new();
            errors = 0;
            results_seen = 0;
            foreach (line_text[i])
            begin
                line_text[i] = '0;
            end
            font = '{
                '{8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e}, '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00},
                '{8'h62, 8'h51, 8'h49, 8'h49, 8'h46}, '{8'h22, 8'h41, 8'h49, 8'h49, 8'h36},
                '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10}, '{8'h2f, 8'h49, 8'h49, 8'h49, 8'h31},
                '{8'h3e, 8'h49, 8'h49, 8'h49, 8'h32}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
                '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h26, 8'h49, 8'h49, 8'h49, 8'h3e},
                '{8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e}, '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36},
                '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c},
                '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01},
                '{8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a}, '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f},
                '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3f, 8'h01},
                '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40},
                '{8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f}, '{8'h7f, 8'h02, 8'h0c, 8'h10, 8'h7f},
                '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h06},
                '{8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e}, '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h46},
                '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01},
                '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}, '{8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f},
                '{8'h7f, 8'h20, 8'h18, 8'h20, 8'h7f}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
                '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
                '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
                '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
                '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
            };
        endfunction

        // Width in pixels of a line of len characters, without the last gap.
        function int line_span(int len, int s);
            return (len > 0) ? len * 6 * s - s : 0;
        endfunction

        // Effective left edge, character count and dot size of the line.
        function void layout(output int x0, output int len, output int s);
            s = settings.glyph_scale;
            if (s < 1)
            begin
                s = 1;
            end
            if (s > SCALE_MAX)
            begin
                s = SCALE_MAX;
            end
            len = (settings.text_length > LINE_MAX) ? LINE_MAX : settings.text_length;
            x0 = int'($signed(settings.origin_x));
            if (settings.layout_mode == MODE_CENTRED)
            begin
                // SystemVerilog division truncates toward zero, as wanted here.
                x0 = (SCREEN_W - line_span(len, s)) / 2;
            end
            else if (settings.layout_mode == MODE_CLIP)
            begin
                while (len > 1 && line_span(len, s) > int'(settings.clip_width))
                begin
                    len--;
                end
            end
        endfunction

        // Character cell under a pixel, or -1 when the pixel lies outside the
        // line. Column and row are the dot position within that cell.
        function int cell_at(int x, int y, output int col, output int row);
            int x0;
            int len;
            int s;
            int dx;
            int dy;
            int idx;
            layout(x0, len, s);
            col = 0;
            row = 0;
            if (x >= SCREEN_W)
            begin
                return -1;
            end
            dx = x - x0;
            dy = y - int'(settings.origin_y);
            if (dx < 0 || dy < 0)
            begin
                return -1;
            end
            idx = dx / (6 * s);
            if (idx >= len)
            begin
                return -1;
            end
            col = (dx % (6 * s)) / s;
            row = dy / s;
            return idx;
        endfunction

        // Row of the font for a character code; lower case shows as upper case.
        function int font_slot(logic [7:0] code);
            logic [7:0] c;
            c = code;
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            begin
                c = c - CASE_OFFSET;
            end
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                return int'(c - CH_ZERO);
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            begin
                return int'(SLOT_LETTER) + int'(c - CH_UPPER_A);
            end
            if (c == CH_COLON)
            begin
                return int'(SLOT_COLON);
            end
            if (c == CH_PERCENT)
            begin
                return int'(SLOT_PERCENT);
            end
            if (c == CH_MINUS)
            begin
                return int'(SLOT_MINUS);
            end
            if (c == CH_DOT)
            begin
                return int'(SLOT_DOT);
            end
            return int'(SLOT_BLANK);
        endfunction

        // Colour that one request gives; a character write updates the store.
        function shade_t shade_pixel(req_t r);
            shade_t     res;
            int         idx;
            int         col;
            int         row;
            logic [7:0] dots;
            res = '0;
            if (r.kind == KIND_WRITE)
            begin
                line_text[r.char_index] = r.char_code;
                return res;
            end
            res.pixel_color = r.background;
            idx = cell_at(r.pixel_x, r.pixel_y, col, row);
            if (idx >= 0 && col < 5 && row < 7)
            begin
                dots = font[font_slot(line_text[idx])][col];
                if (dots[row])
                begin
                    res.pixel_color = settings.text_color;
                    res.covered = 1'b1;
                end
            end
            return res;
        endfunction

        function void note_request(req_t r);
            colours_due.push_back(shade_pixel(r));
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: result %0d: %s", $time, results_seen, what);
            errors++;
        endtask

        task check_result(logic [15:0] pixel_color, logic covered);
            shade_t due;
            results_seen++;
            if (colours_due.size() == 0)
            begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            due = colours_due.pop_front();
            if (pixel_color !== due.pixel_color)
            begin
                report_mismatch($sformatf("pixel_color %h, expected %h",
                                          pixel_color, due.pixel_color));
            end
            if (covered !== due.covered)
            begin
                report_mismatch($sformatf("covered %b, expected %b", covered, due.covered));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    tog_req_if request_bus ();
    tog_rsp_if result_bus ();

    overlay_model book = new();

    // Text store entries written so far, as the stimulus sees them.
    bit stored [LINE_MAX];

    // With steady_flow set neither side idles. want_hold asks the result side
    // for one long stall, which it times itself.
    bit steady_flow = 1'b0;
    bit want_hold   = 1'b0;
    bit hold_taken  = 1'b0;
    int hold_cycles = 0;

    string glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz:%-.";

    text_overlay_glyph_rasterizer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Upper bound on the run: far beyond the slowest correct run, even
    // with every stall at its longest.
    initial
    begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The result side: ready at random, with the one long stall on request.
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_bus.ready <= 1'b0;
        end
        else if (want_hold && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_cycles <= HOLD_LENGTH - 1;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 25);
        end
    end

    // Both handshakes are sampled at the clock edge, before any of this
    // edge's updates take effect, so a request is always noted before the
    // result that it causes is checked.
    always @(posedge clk)
    begin : watch
        req_t seen;
        if (rst_n)
        begin
            if (request_bus.valid && request_bus.ready)
            begin
                seen.kind       = request_bus.kind;
                seen.char_index = request_bus.char_index;
                seen.char_code  = request_bus.char_code;
                seen.pixel_x    = request_bus.pixel_x;
                seen.pixel_y    = request_bus.pixel_y;
                seen.background = request_bus.background;
                book.note_request(seen);
            end
            if (result_bus.valid && result_bus.ready)
            begin
                book.check_result(result_bus.pixel_color, result_bus.covered);
            end
        end
    end

    function automatic cfg_t make_cfg(int ox, int oy, int sc, int colour, int len,
                                      int clip, logic [1:0] mode);
        cfg_t c;
        c.origin_x    = 11'(ox);
        c.origin_y    = 10'(oy);
        c.glyph_scale = 4'(sc);
        c.text_color  = 16'(colour);
        c.text_length = 6'(len);
        c.clip_width  = 10'(clip);
        c.layout_mode = mode;
        return c;
    endfunction

    task automatic put_register(cfg_reg_t r, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Writes all seven registers back to back; only called with nothing in
    // flight, so the new settings hold for every following request.
    task automatic apply_settings(cfg_t c);
        put_register(REG_ORIGIN_X, 16'(c.origin_x));
        put_register(REG_ORIGIN_Y, 16'(c.origin_y));
        put_register(REG_GLYPH_SCALE, 16'(c.glyph_scale));
        put_register(REG_TEXT_COLOR, c.text_color);
        put_register(REG_TEXT_LENGTH, 16'(c.text_length));
        put_register(REG_CLIP_WIDTH, 16'(c.clip_width));
        put_register(REG_LAYOUT_MODE, 16'(c.layout_mode));
        cfg_we <= 1'b0;
        book.settings = c;
    endtask

    // Offers one request and returns at the edge where it is taken. A pixel
    // that would show a store entry never written becomes a write to it.
    task automatic offer(req_t item);
        int col;
        int row;
        int idx;
        if (item.kind == KIND_PIXEL)
        begin
            idx = book.cell_at(item.pixel_x, item.pixel_y, col, row);
            if (idx >= 0 && !stored[idx])
            begin
                item.kind = KIND_WRITE;
                item.char_index = 5'(idx);
            end
        end
        if (item.kind == KIND_WRITE)
        begin
            stored[item.char_index] = 1'b1;
        end
        while (!steady_flow && $urandom_range(0, 99) < 25)
        begin
            request_bus.valid <= 1'b0;
            @(posedge clk);
        end
        request_bus.valid      <= 1'b1;
        request_bus.kind       <= item.kind;
        request_bus.char_index <= item.char_index;
        request_bus.char_code  <= item.char_code;
        request_bus.pixel_x    <= item.pixel_x;
        request_bus.pixel_y    <= item.pixel_y;
        request_bus.background <= item.background;
        @(posedge clk);
        while (!request_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    // A request with random contents in every field.
    function automatic req_t noise_request();
        req_t it;
        it.kind       = 1'($urandom);
        it.char_index = 5'($urandom);
        it.char_code  = 8'($urandom);
        it.pixel_x    = 10'($urandom);
        it.pixel_y    = 10'($urandom);
        it.background = 16'($urandom);
        return it;
    endfunction

    task automatic offer_write(int idx, logic [7:0] code);
        req_t it;
        it = noise_request();
        it.kind = KIND_WRITE;
        it.char_index = 5'(idx);
        it.char_code = code;
        offer(it);
    endtask

    task automatic offer_pixel(int x, int y, logic [15:0] bg);
        req_t it;
        it = noise_request();
        it.kind = KIND_PIXEL;
        it.pixel_x = 10'(x);
        it.pixel_y = 10'(y);
        it.background = bg;
        offer(it);
    endtask

    // Mostly pixels in and around the visible line, some character writes
    // and some pixels at any coordinates, on or off the screen.
    function automatic req_t random_request();
        req_t it;
        int   pick;
        int   x0;
        int   len;
        int   s;
        int   x;
        int   y;
        it = noise_request();
        book.layout(x0, len, s);
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            it.kind = KIND_WRITE;
            if (len > 0 && $urandom_range(0, 3) != 0)
            begin
                it.char_index = 5'($urandom_range(0, len - 1));
            end
            if ($urandom_range(0, 9) < 7)
            begin
                it.char_code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
            end
        end
        else if (pick < 80)
        begin
            it.kind = KIND_PIXEL;
            x = x0 - 3;
            x = x + int'($urandom_range(0, len * 6 * s + 6));
            if (x < 0 || x > 1023)
            begin
                x = $urandom_range(0, 1023);
            end
            y = int'(book.settings.origin_y) - 2;
            y = y + int'($urandom_range(0, 7 * s + 3));
            it.pixel_x = 10'(x);
            it.pixel_y = 10'(y);
        end
        else
        begin
            it.kind = KIND_PIXEL;
        end
        return it;
    endfunction

    // The first few settings are chosen for their extremes; the rest are
    // random, mostly with the line on screen.
    function automatic cfg_t settings_for(int phase);
        cfg_t c;
        int   ox;
        ox = $urandom_range(0, 260);
        ox = ox - 40;
        if ($urandom_range(0, 5) == 0)
        begin
            ox = $urandom_range(0, 2047);
            ox = ox - 1024;
        end
        c = make_cfg(ox, $urandom_range(0, 1023), $urandom_range(1, SCALE_MAX),
                     $urandom_range(0, 65535), $urandom_range(1, LINE_MAX),
                     $urandom_range(0, 1023), 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 4) == 0)
        begin
            c.glyph_scale = 4'($urandom);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            c.text_length = 6'($urandom);
        end
        case (phase)
            // Widest line, centred far off the left edge.
            0: c = make_cfg(0, 0, 15, 16'hFFFF, 63, 0, MODE_CENTRED);
            // Origin at the far corner and an empty line.
            1: c = make_cfg(1023, 1023, 1, 16'h0000, 0, 1023, MODE_PLAIN);
            // Widest clip with the largest dots; the long receiver stall.
            2: c = make_cfg(-1024, 1016, 8, 16'h07E0, 32, 1023, MODE_CLIP);
            // Clip narrower than one character still keeps the first one.
            3: c = make_cfg(5, 3, 2, 16'h001F, 12, 0, MODE_CLIP);
            // Scale zero, the spare mode and a length above the store size.
            4: c = make_cfg(17, 40, 0, 16'hF81F, 40, 100, MODE_SPARE);
            5: c.origin_x = -11'sd20;
            default: ;
        endcase
        return c;
    endfunction

    // Lets everything outstanding come out before returning.
    task automatic settle();
        request_bus.valid <= 1'b0;
        @(posedge clk);
        while (book.colours_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        request_bus.valid = 1'b0;
        request_bus.kind = KIND_WRITE;
        request_bus.char_index = '0;
        request_bus.char_code = '0;
        request_bus.pixel_x = '0;
        request_bus.pixel_y = '0;
        request_bus.background = '0;
        result_bus.ready = 1'b0;
        book.settings = make_cfg(0, 0, 1, 16'hFFFF, 0, 1023, MODE_PLAIN);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With the reset settings the line is empty, so the
        // first pixels are never covered, the far corner among them.
        offer_write(0, CH_ZERO);
        offer_write(1, CH_UPPER_A);
        offer_write(2, CH_LOWER_Z);
        offer_write(3, CH_COLON);
        offer_write(4, CH_PERCENT);
        offer_write(5, CH_MINUS);
        offer_write(6, CH_DOT);
        offer_write(7, 8'hFF);
        offer_write(8, 8'h00);
        offer_write(LINE_MAX - 1, CH_UPPER_Z);
        offer_pixel(0, 1, 16'h0000);
        offer_pixel(1023, 1023, 16'hFFFF);
        settle();

        // Nine characters at the top left; each pixel below hits a known dot,
        // a gap column, the row below the glyph, a blank cell, the first cell
        // past the line or the right of the screen.
        apply_settings(make_cfg(0, 0, 1, 16'hF800, 9, 1023, MODE_PLAIN));
        offer_pixel(0, 1, 16'h1234);
        offer_pixel(5, 1, 16'h1234);
        offer_pixel(8, 0, 16'hFFFF);
        offer_pixel(12, 0, 16'h0000);
        offer_pixel(12, 7, 16'h5555);
        offer_pixel(19, 1, 16'hAAAA);
        offer_pixel(24, 0, 16'h0F0F);
        offer_pixel(32, 3, 16'hF0F0);
        offer_pixel(37, 5, 16'h00FF);
        offer_pixel(44, 3, 16'hFF00);
        offer_pixel(50, 3, 16'h8001);
        offer_pixel(54, 0, 16'h7FFE);
        offer_pixel(SCREEN_W, 1, 16'hC3C3);
        offer_pixel(1023, 0, 16'h3C3C);
        settle();

        // Random part: one burst per setting. In the third burst the result
        // side stalls for a long stretch while requests keep coming, so the
        // pipeline fills and holds off the request side; the fourth runs with
        // no idling on either side. Between bursts the request side waits for
        // every result before the registers change.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            apply_settings(settings_for(phase));
            steady_flow = (phase == 3);
            want_hold = (phase == 2);
            repeat (PHASE_REQUESTS) offer(random_request());
            settle();
        end
        steady_flow = 1'b0;

        if (book.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
